// ===== hw/rtl/tpws_pkg.sv =====
// shared types and constants for the tick prescaler with wakeup slots
package tpws_pkg;

   // default sizes handed to the top level
   localparam int WAKEUP_SLOTS_DEFAULT = 8;
   localparam int TICK_BITS_DEFAULT    = 48;

   // fixed field widths
   localparam int TPS_BITS       = 20;
   localparam int MILLI_BITS     = 10;
   localparam int PERIOD_BITS    = 36;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // reset values of frequency and countdowns
   localparam logic [TPS_BITS-1:0]   TPS_RESET   = 20'd1000;
   localparam logic [MILLI_BITS-1:0] MILLI_RESET = 10'd1;

   // divide by 1000 as multiply by ceil(2^30 / 1000), exact for 20-bit values
   localparam int                 MS_SHIFT        = 30;
   localparam int                 RECIP_PROD_BITS = 41;
   localparam logic [20:0]        MS_RECIP        = 21'd1073742;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TPS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOD    = 2'd2;

   // item opcodes
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_ARM  = 1'b1
   } opcode_type;

   // slot table write controls
   typedef struct packed {
      logic deadline_we;
      logic arm_we;
   } slot_wr_type;

endpackage

// ===== hw/rtl/tpws_alu.sv =====
// shared add and compare unit for deadline and tick count arithmetic
module tpws_alu #(
   parameter int TICK_BITS = tpws_pkg::TICK_BITS_DEFAULT
) (
   input  logic [TICK_BITS-1:0] a,
   input  logic [TICK_BITS-1:0] add_b,
   input  logic [TICK_BITS-1:0] cmp_b,
   output logic [TICK_BITS-1:0] sum,
   output logic                 a_ge
);

   // wrapping add for arm, re-arm and increment
   assign sum = a + add_b;

   // unsigned deadline check
   assign a_ge = (a >= cmp_b);

endmodule

// ===== hw/rtl/tpws_slots.sv =====
// wakeup slot table: deadlines, frozen periods and armed bits
module tpws_slots #(
   parameter int WAKEUP_SLOTS = tpws_pkg::WAKEUP_SLOTS_DEFAULT,
   parameter int TICK_BITS    = tpws_pkg::TICK_BITS_DEFAULT,
   parameter int IDX_BITS     = (WAKEUP_SLOTS > 1) ? $clog2(WAKEUP_SLOTS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tpws_pkg::slot_wr_type              wr_ctl,
   input  logic [IDX_BITS-1:0]                wr_idx,
   input  logic [TICK_BITS-1:0]               wr_deadline,
   input  logic [tpws_pkg::PERIOD_BITS-1:0]   wr_period,
   input  logic [IDX_BITS-1:0]                rd_idx,
   output logic [TICK_BITS-1:0]               rd_deadline,
   output logic [tpws_pkg::PERIOD_BITS-1:0]   rd_period,
   output logic                               rd_armed
);
   import tpws_pkg::*;

   logic [TICK_BITS-1:0]   deadline_ff [WAKEUP_SLOTS];
   logic [PERIOD_BITS-1:0] period_ff   [WAKEUP_SLOTS];
   logic [WAKEUP_SLOTS-1:0] armed_ff;

   // armed bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else if (wr_ctl.arm_we) begin
         armed_ff[wr_idx] <= 1'b1;
      end
   end

   // deadline and period storage
   always_ff @(posedge clock) begin
      if (wr_ctl.deadline_we) begin
         deadline_ff[wr_idx] <= wr_deadline;
      end
      if (wr_ctl.arm_we) begin
         period_ff[wr_idx] <= wr_period;
      end
   end

   // one read port walked by the sequencer
   assign rd_deadline = deadline_ff[rd_idx];
   assign rd_period   = period_ff[rd_idx];
   assign rd_armed    = armed_ff[rd_idx];

endmodule

// ===== hw/rtl/tick_prescaler_with_wakeup_slots.sv =====
// top level: tick prescaler with periodic wakeup slots
//
// Items enter on the req_ channel (valid/stall). Opcode tick advances the
// prescaler when the timer is enabled; opcode arm loads a wakeup slot with a
// period of whole seconds. Every item yields exactly one result on the rsp_
// channel with the event flags, the fired-slot mask and the counts after it.
// Configuration is a plain write port (csr_we, csr_index, csr_wdata); writes
// must go in only while the block is idle, a rule the block leaves to the user.
// Sequence: an enabled tick walks all WAKEUP_SLOTS slots in turn, since one
// add/compare unit checks one slot per cycle, then the countdowns and tick
// count are updated. An arm goes through multiply, add and result, a disabled
// tick straight to the result. One item is in flight at a time; req_stall is
// high while it is worked on, and the next item is taken the cycle after the
// result is loaded.
// The result sits in an output register: a stalled receiver holds it, the
// next item may already be taken, and its result waits until the register
// frees up. Reset clears all counts, disarms every slot, sets the frequency
// to 1000 and leaves the timer disabled; the first item can enter right away.
module tick_prescaler_with_wakeup_slots #(
   parameter int WAKEUP_SLOTS = tpws_pkg::WAKEUP_SLOTS_DEFAULT,
   parameter int TICK_BITS    = tpws_pkg::TICK_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [tpws_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpws_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic                                  req_process_running,
   input  logic [2:0]                            req_slot_index,
   input  logic [15:0]                           req_period_seconds,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_ms_tick,
   output logic                                  rsp_second_tick,
   output logic                                  rsp_process_tick,
   output logic [7:0]                            rsp_wakeup_fired,
   output logic [31:0]                           rsp_ms_count,
   output logic [31:0]                           rsp_seconds_count,
   output logic [31:0]                           rsp_time_of_day,
   output logic [47:0]                           rsp_tick_total
);
   import tpws_pkg::*;

   localparam int IDX_BITS = (WAKEUP_SLOTS > 1) ? $clog2(WAKEUP_SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARM_MUL,
      ST_ARM_ADD,
      ST_SCAN,
      ST_COUNT,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   logic [IDX_BITS-1:0]     idx_ff;
   opcode_type              opcode_ff;
   logic                    running_ff;
   logic [2:0]              slot_ff;
   logic [15:0]             period_ff;
   logic [PERIOD_BITS-1:0]  product_ff;

   logic [TPS_BITS-1:0]     tps_ff;
   logic [MILLI_BITS-1:0]   reload_ff;
   logic                    enable_ff;
   logic [TICK_BITS-1:0]    tick_ff;
   logic [TPS_BITS-1:0]     sec_cd_ff;
   logic [MILLI_BITS-1:0]   milli_cd_ff;
   logic [31:0]             milli_total_ff;
   logic [31:0]             second_total_ff;
   logic [31:0]             clock_ff;

   logic [WAKEUP_SLOTS-1:0] fired_ff;
   logic                    ms_flag_ff;
   logic                    sec_flag_ff;
   logic                    proc_flag_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_ms_tick_ff;
   logic                    rsp_second_tick_ff;
   logic                    rsp_process_tick_ff;
   logic [7:0]              rsp_wakeup_fired_ff;
   logic [31:0]             rsp_ms_count_ff;
   logic [31:0]             rsp_seconds_count_ff;
   logic [31:0]             rsp_time_of_day_ff;
   logic [47:0]             rsp_tick_total_ff;

   logic [RECIP_PROD_BITS-1:0] recip_prod;
   logic [MILLI_BITS-1:0]      reload_in;
   logic                       milli_zero;
   logic                       sec_zero;
   logic [MILLI_BITS-1:0]      milli_cd_in;
   logic [TPS_BITS-1:0]        sec_cd_in;

   logic [63:0]             period_ext;
   logic [63:0]             product_ext;
   logic [63:0]             tick_ext;
   logic [39:0]             fired_ext;
   logic [31:0]             slot_ext;
   logic                    slot_ok;
   logic                    slot_hit;
   logic                    out_free;

   logic [TICK_BITS-1:0]    add_b;
   logic [TICK_BITS-1:0]    alu_sum;
   logic                    alu_ge;

   slot_wr_type             slot_wr;
   logic [IDX_BITS-1:0]     wr_idx;
   logic [TICK_BITS-1:0]    rd_deadline;
   logic [PERIOD_BITS-1:0]  rd_period;
   logic                    rd_armed;

   // frequency divided by 1000 for the millisecond reload
   assign recip_prod = RECIP_PROD_BITS'(csr_wdata[TPS_BITS-1:0])
                     * RECIP_PROD_BITS'(MS_RECIP);
   assign reload_in  = recip_prod[MS_SHIFT +: MILLI_BITS];

   // countdown next values, reloading on expiry
   assign milli_zero  = (milli_cd_ff == '0);
   assign sec_zero    = (sec_cd_ff == '0);
   assign milli_cd_in = MILLI_BITS'((milli_zero ? reload_ff : milli_cd_ff) - 1'b1);
   assign sec_cd_in   = TPS_BITS'((sec_zero ? tps_ff : sec_cd_ff) - 1'b1);

   // width adaptation of stored values
   assign period_ext  = 64'(rd_period);
   assign product_ext = 64'(product_ff);
   assign tick_ext    = 64'(tick_ff);
   assign fired_ext   = 40'(fired_ff);
   assign slot_ext    = 32'(slot_ff);
   assign slot_ok     = (slot_ext < 32'(WAKEUP_SLOTS));

   // operand select for the shared unit
   always_comb begin
      add_b = TICK_BITS'(1);
      case (state_ff)
         ST_SCAN:    add_b = period_ext[TICK_BITS-1:0];
         ST_ARM_ADD: add_b = product_ext[TICK_BITS-1:0];
         default:    add_b = TICK_BITS'(1);
      endcase
   end

   tpws_alu #(
      .TICK_BITS (TICK_BITS)
   ) u_alu (
      .a     (tick_ff),
      .add_b (add_b),
      .cmp_b (rd_deadline),
      .sum   (alu_sum),
      .a_ge  (alu_ge)
   );

   // slot table writes: re-arm on a hit, full load on an arm item
   assign slot_hit            = (state_ff == ST_SCAN) && rd_armed && alu_ge;
   assign slot_wr.arm_we      = (state_ff == ST_ARM_ADD) && slot_ok;
   assign slot_wr.deadline_we = slot_hit || slot_wr.arm_we;
   assign wr_idx              = (state_ff == ST_SCAN) ? idx_ff : slot_ext[IDX_BITS-1:0];

   tpws_slots #(
      .WAKEUP_SLOTS (WAKEUP_SLOTS),
      .TICK_BITS    (TICK_BITS),
      .IDX_BITS     (IDX_BITS)
   ) u_slots (
      .clock       (clock),
      .reset       (reset),
      .wr_ctl      (slot_wr),
      .wr_idx      (wr_idx),
      .wr_deadline (alu_sum),
      .wr_period   (product_ff),
      .rd_idx      (idx_ff),
      .rd_deadline (rd_deadline),
      .rd_period   (rd_period),
      .rd_armed    (rd_armed)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, counters, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         tps_ff          <= TPS_RESET;
         reload_ff       <= MILLI_RESET;
         enable_ff       <= 1'b0;
         tick_ff         <= '0;
         sec_cd_ff       <= TPS_RESET;
         milli_cd_ff     <= MILLI_RESET;
         milli_total_ff  <= '0;
         second_total_ff <= '0;
         clock_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // receiver took the result
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  opcode_ff    <= opcode_type'(req_opcode);
                  running_ff   <= req_process_running;
                  slot_ff      <= req_slot_index;
                  period_ff    <= req_period_seconds;
                  idx_ff       <= '0;
                  fired_ff     <= '0;
                  ms_flag_ff   <= 1'b0;
                  sec_flag_ff  <= 1'b0;
                  proc_flag_ff <= 1'b0;
                  if (opcode_type'(req_opcode) == OP_ARM) begin
                     state_ff <= ST_ARM_MUL;
                  end else if (enable_ff) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_ARM_MUL: begin
               product_ff <= PERIOD_BITS'(tps_ff) * PERIOD_BITS'(period_ff);
               state_ff   <= ST_ARM_ADD;
            end
            ST_ARM_ADD: begin
               state_ff <= ST_FINISH;
            end
            ST_SCAN: begin
               if (slot_hit) begin
                  fired_ff[idx_ff] <= 1'b1;
               end
               if (idx_ff == IDX_BITS'(WAKEUP_SLOTS - 1)) begin
                  state_ff <= ST_COUNT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_COUNT: begin
               if (milli_zero) begin
                  milli_total_ff <= milli_total_ff + 32'd1;
                  ms_flag_ff     <= 1'b1;
                  proc_flag_ff   <= running_ff;
               end
               if (sec_zero) begin
                  second_total_ff <= second_total_ff + 32'd1;
                  clock_ff        <= clock_ff + 32'd1;
                  sec_flag_ff     <= 1'b1;
               end
               milli_cd_ff <= milli_cd_in;
               sec_cd_ff   <= sec_cd_in;
               tick_ff     <= alu_sum;
               state_ff    <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ms_tick_ff       <= ms_flag_ff;
                  rsp_second_tick_ff   <= sec_flag_ff;
                  rsp_process_tick_ff  <= proc_flag_ff;
                  rsp_wakeup_fired_ff  <= fired_ext[7:0];
                  rsp_ms_count_ff      <= milli_total_ff;
                  rsp_seconds_count_ff <= second_total_ff;
                  rsp_time_of_day_ff   <= clock_ff;
                  rsp_tick_total_ff    <= tick_ext[47:0];
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // configuration writes, which the user must make only while idle; unchecked here
         if (csr_we) begin
            unique case (csr_index)
               CSR_TPS: begin
                  tps_ff      <= csr_wdata[TPS_BITS-1:0];
                  reload_ff   <= reload_in;
                  sec_cd_ff   <= csr_wdata[TPS_BITS-1:0];
                  milli_cd_ff <= reload_in;
                  tick_ff     <= '0;
               end
               CSR_ENABLE: enable_ff <= csr_wdata[0];
               CSR_TOD:    clock_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // port drive
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ms_tick       = rsp_ms_tick_ff;
   assign rsp_second_tick   = rsp_second_tick_ff;
   assign rsp_process_tick  = rsp_process_tick_ff;
   assign rsp_wakeup_fired  = rsp_wakeup_fired_ff;
   assign rsp_ms_count      = rsp_ms_count_ff;
   assign rsp_seconds_count = rsp_seconds_count_ff;
   assign rsp_time_of_day   = rsp_time_of_day_ff;
   assign rsp_tick_total    = rsp_tick_total_ff;

   // an accepted item always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted item did not leave idle");

   // a process tick only comes with a millisecond tick
   a_proc_needs_ms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_process_tick_ff || rsp_ms_tick_ff))
      else $error("process tick without millisecond tick");

   // an arm item reports no events
   a_arm_no_events: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && opcode_ff == OP_ARM
      |-> fired_ff == '0 && !ms_flag_ff && !sec_flag_ff && !proc_flag_ff)
      else $error("arm item carries events");

   // slot walk stays inside the table
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> 32'(idx_ff) < 32'(WAKEUP_SLOTS))
      else $error("slot walk out of range");

   // a new result only comes out of the finish step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside finish step");

endmodule
